### rtl/wpch_pkg.sv
// Shared constants, codes and control types of the word pair correlation histogram.
`default_nettype none

package wpch_pkg;

   // Field widths fixed by the channel definition
   localparam int WORD_W     = 12;
   localparam int WEIGHT_W   = 20;
   localparam int BETA_W     = 4;
   localparam int RDIDX_W    = 12;
   localparam int CORR_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 48;
   localparam int TOTAL_W    = 13;
   localparam int FIRST_W    = 2 * WORD_W + BETA_W;

   // Configuration registers
   localparam int WL_W       = 3;
   localparam int CB_W       = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_LEN  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHAR_BITS = 1'd1;
   localparam logic [WL_W-1:0] WL_RESET = 3'd4;
   localparam logic [CB_W-1:0] CB_RESET = 2'd3;
   localparam logic [WL_W-1:0] WL_MIN   = 3'd2;
   localparam logic [CB_W-1:0] CB_MIN   = 2'd1;

   // Parameter defaults
   localparam int DEF_MAX_WORD_LEN  = 4;
   localparam int DEF_MAX_CHAR_BITS = 3;

   // Commands
   localparam logic CMD_ACC  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SKIP     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

   // Report rule thresholds on beta
   localparam logic [BETA_W-1:0] REPORT_BETA_MIN = 4'd3;
   localparam logic [BETA_W-1:0] STORED_BETA_MIN = 4'd2;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic calc;
      logic mem_read;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_blocked;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/wpch_corr.sv
// Correlation bit vector of two masked words over shifts 1 to T-1.
`default_nettype none

module wpch_corr #(
   parameter int MAX_WORD_LEN = wpch_pkg::DEF_MAX_WORD_LEN
) (
   input  wire logic [wpch_pkg::WORD_W-1:0] a,
   input  wire logic [wpch_pkg::WORD_W-1:0] b,
   input  wire logic [wpch_pkg::WL_W-1:0]   t,
   input  wire logic [wpch_pkg::CB_W-1:0]   cb,
   output logic      [MAX_WORD_LEN-2:0]     v
);

   localparam int CW   = MAX_WORD_LEN - 1;
   localparam int SH_W = 5;

   logic [CW-1:0]            raw;
   logic [wpch_pkg::WL_W-1:0] drop;

   // Shift 1 lands at the top bit; shifts at or beyond T read as zero
   for (genvar k = 1; k <= CW; k++) begin : g_shift
      logic [SH_W-1:0]             shift_amt;
      logic [SH_W-1:0]             len;
      logic [wpch_pkg::WORD_W-1:0] diff;
      logic [wpch_pkg::WORD_W-1:0] mask;

      assign shift_amt = SH_W'(k) * SH_W'(cb);
      assign len       = (SH_W'(t) - SH_W'(k)) * SH_W'(cb);
      assign diff      = a ^ (b >> shift_amt);
      assign mask      = (len >= SH_W'(wpch_pkg::WORD_W)) ? '1
                       : ((wpch_pkg::WORD_W'(1) << len) - wpch_pkg::WORD_W'(1));
      assign raw[CW-k] = (SH_W'(k) < SH_W'(t)) && ((diff & mask) == '0);
   end

   // Align so the vector holds T-1 bits with shift 1 most significant
   assign drop = wpch_pkg::WL_W'(MAX_WORD_LEN) - t;
   assign v    = raw >> drop;

endmodule

`default_nettype wire

### rtl/wpch_ctrl.sv
// Sequencing state machine: clearing pass, then accept, correlate, read, update.
`default_nettype none

module wpch_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire wpch_pkg::dp_status_type stat,
   output wpch_pkg::ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CALC   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            // hold while the result register is full and stalled
            if (!stat.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);

endmodule

`default_nettype wire

### rtl/wpch_datapath.sv
// Datapath: configuration, input capture, correlation, histogram memories, result register.
`default_nettype none

module wpch_datapath #(
   parameter int MAX_WORD_LEN  = wpch_pkg::DEF_MAX_WORD_LEN,
   parameter int MAX_CHAR_BITS = wpch_pkg::DEF_MAX_CHAR_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire wpch_pkg::ctrl_cmd_type             cmd,
   output wpch_pkg::dp_status_type                 stat,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [wpch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wpch_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                               req_cmd,
   input  wire logic [wpch_pkg::WORD_W-1:0]        req_word_x,
   input  wire logic [wpch_pkg::WORD_W-1:0]        req_word_y,
   input  wire logic [wpch_pkg::WEIGHT_W-1:0]      req_weight,
   input  wire logic [wpch_pkg::BETA_W-1:0]        req_distinct_chars,
   input  wire logic [wpch_pkg::RDIDX_W-1:0]       req_read_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_xy,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_yx,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_xx,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_yy,
   output logic      [wpch_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                    rsp_report,
   output logic      [wpch_pkg::WORD_W-1:0]        rsp_stored_x,
   output logic      [wpch_pkg::WORD_W-1:0]        rsp_stored_y,
   output logic      [wpch_pkg::BETA_W-1:0]        rsp_stored_beta,
   output logic      [wpch_pkg::COUNT_W-1:0]       rsp_count,
   output logic      [wpch_pkg::TOTAL_W-1:0]       rsp_classes_total,
   output logic      [wpch_pkg::COUNT_W-1:0]       rsp_pairs_total
);

   localparam int CW    = MAX_WORD_LEN - 1;
   localparam int IDX_W = 4 * CW;
   localparam int DEPTH = 1 << IDX_W;
   localparam int TOT_W = IDX_W + 1;
   localparam int WW    = wpch_pkg::WORD_W;
   localparam int BW    = wpch_pkg::BETA_W;
   localparam int CNT_W = wpch_pkg::COUNT_W;
   localparam int FW    = wpch_pkg::FIRST_W;
   localparam int CRW   = wpch_pkg::CORR_W;

   // ---------------- configuration ----------------
   logic [wpch_pkg::WL_W-1:0] word_length_ff;
   logic [wpch_pkg::CB_W-1:0] char_bits_ff;
   logic [wpch_pkg::WL_W-1:0] t_eff;
   logic [wpch_pkg::CB_W-1:0] cb_eff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= wpch_pkg::WL_RESET;
         char_bits_ff   <= wpch_pkg::CB_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wpch_pkg::REG_WORD_LEN:  word_length_ff <= csr_data[wpch_pkg::WL_W-1:0];
            wpch_pkg::REG_CHAR_BITS: char_bits_ff   <= csr_data[wpch_pkg::CB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp register values into the supported range
   always_comb begin
      if (word_length_ff < wpch_pkg::WL_MIN) begin
         t_eff = wpch_pkg::WL_MIN;
      end else if (int'(word_length_ff) > MAX_WORD_LEN) begin
         t_eff = wpch_pkg::WL_W'(MAX_WORD_LEN);
      end else begin
         t_eff = word_length_ff;
      end
      if (char_bits_ff < wpch_pkg::CB_MIN) begin
         cb_eff = wpch_pkg::CB_MIN;
      end else if (int'(char_bits_ff) > MAX_CHAR_BITS) begin
         cb_eff = wpch_pkg::CB_W'(MAX_CHAR_BITS);
      end else begin
         cb_eff = char_bits_ff;
      end
   end

   // ---------------- input capture ----------------
   logic                   in_cmd_ff;
   logic [WW-1:0]          x_ff;
   logic [WW-1:0]          y_ff;
   logic [wpch_pkg::WEIGHT_W-1:0] weight_ff;
   logic [BW-1:0]          beta_ff;
   logic [wpch_pkg::RDIDX_W-1:0]  rd_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_cmd_ff <= req_cmd;
         x_ff      <= req_word_x;
         y_ff      <= req_word_y;
         weight_ff <= req_weight;
         beta_ff   <= req_distinct_chars;
         rd_idx_ff <= req_read_index;
      end
   end

   // ---------------- correlation ----------------
   logic [4:0]    wbits;
   logic [WW-1:0] wmask;
   logic [WW-1:0] a_m;
   logic [WW-1:0] b_m;
   logic [CW-1:0] xy_v;
   logic [CW-1:0] yx_v;
   logic [CW-1:0] xx_v;
   logic [CW-1:0] yy_v;
   logic [CW-1:0] cross_hi;
   logic [CW-1:0] cross_lo;
   logic [CW-1:0] auto_hi;
   logic [CW-1:0] auto_lo;
   logic [IDX_W-1:0] idx_acc;
   logic [IDX_W-1:0] idx_read;
   logic [IDX_W+wpch_pkg::RDIDX_W-1:0] rd_idx_pad;

   assign wbits = 5'(t_eff) * 5'(cb_eff);
   assign wmask = (wbits >= 5'(WW)) ? '1 : ((WW'(1) << wbits) - WW'(1));
   assign a_m   = x_ff & wmask;
   assign b_m   = y_ff & wmask;

   wpch_corr #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_corr_xy (
      .a(a_m), .b(b_m), .t(t_eff), .cb(cb_eff), .v(xy_v)
   );
   wpch_corr #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_corr_yx (
      .a(b_m), .b(a_m), .t(t_eff), .cb(cb_eff), .v(yx_v)
   );
   wpch_corr #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_corr_xx (
      .a(a_m), .b(a_m), .t(t_eff), .cb(cb_eff), .v(xx_v)
   );
   wpch_corr #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_corr_yy (
      .a(b_m), .b(b_m), .t(t_eff), .cb(cb_eff), .v(yy_v)
   );

   assign cross_hi = (xy_v < yx_v) ? yx_v : xy_v;
   assign cross_lo = (xy_v < yx_v) ? xy_v : yx_v;
   assign auto_hi  = (xx_v < yy_v) ? yy_v : xx_v;
   assign auto_lo  = (xx_v < yy_v) ? xx_v : yy_v;
   assign idx_acc  = {cross_hi, cross_lo, auto_hi, auto_lo};

   assign rd_idx_pad = {IDX_W'(0), rd_idx_ff};
   assign idx_read   = rd_idx_pad[IDX_W-1:0];

   logic [WW-1:0]    a_ff;
   logic [WW-1:0]    b_ff;
   logic             skip_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         a_ff    <= a_m;
         b_ff    <= b_m;
         skip_ff <= (a_m == b_m);
         idx_ff  <= (in_cmd_ff == wpch_pkg::CMD_READ) ? idx_read : idx_acc;
      end
   end

   // ---------------- histogram memories ----------------
   logic [CNT_W-1:0] count_mem [DEPTH];
   logic [FW-1:0]    first_mem [DEPTH];
   logic [CNT_W-1:0] count_rd_ff;
   logic [FW-1:0]    first_rd_ff;
   logic [IDX_W-1:0] clr_addr_ff;

   logic             count_we;
   logic [IDX_W-1:0] count_wa;
   logic [CNT_W-1:0] count_wd;
   logic             first_we;
   logic [FW-1:0]    first_wd;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         count_rd_ff <= count_mem[idx_ff];
         first_rd_ff <= first_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_wa] <= count_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[idx_ff] <= first_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + IDX_W'(1);
      end
   end

   // ---------------- update ----------------
   logic             is_read;
   logic             acc_hit;
   logic             old_zero;
   logic [CNT_W:0]   cnt_sum;
   logic [CNT_W-1:0] cnt_new;
   logic [CNT_W:0]   tot_sum;
   logic [CNT_W-1:0] tot_new;
   logic [BW-1:0]    sb;
   logic             rep_old;
   logic [WW-1:0]    first_x;
   logic [WW-1:0]    first_y;
   logic [CW+CRW-1:0] f_xy_pad;
   logic [CW+CRW-1:0] f_yx_pad;
   logic [CW+CRW-1:0] f_xx_pad;
   logic [CW+CRW-1:0] f_yy_pad;

   logic [TOT_W-1:0] class_total_ff;
   logic [TOT_W-1:0] class_total_in;
   logic [CNT_W-1:0] weight_total_ff;
   logic [CNT_W-1:0] weight_total_in;

   assign is_read  = (in_cmd_ff == wpch_pkg::CMD_READ);
   assign acc_hit  = !is_read && !skip_ff;
   assign old_zero = (count_rd_ff == '0);
   assign cnt_sum  = {1'b0, count_rd_ff} + (CNT_W + 1)'(weight_ff);
   assign cnt_new  = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
   assign tot_sum  = {1'b0, weight_total_ff} + (CNT_W + 1)'(weight_ff);
   assign tot_new  = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
   assign sb       = first_rd_ff[BW-1:0];
   assign first_x  = first_rd_ff[FW-1 -: WW];
   assign first_y  = first_rd_ff[BW +: WW];
   assign rep_old  = (beta_ff > wpch_pkg::REPORT_BETA_MIN) && (beta_ff > sb)
                  && (sb > wpch_pkg::STORED_BETA_MIN);

   // Memory write ports: clearing pass or the committed update
   always_comb begin
      count_we = cmd.clear_step || (cmd.commit && acc_hit);
      count_wa = cmd.clear_step ? clr_addr_ff : idx_ff;
      count_wd = cmd.clear_step ? '0 : cnt_new;
      first_we = cmd.commit && acc_hit && (old_zero || rep_old);
      first_wd = old_zero ? {a_ff, b_ff, beta_ff} : {first_rd_ff[FW-1:BW], beta_ff};
   end

   assign class_total_in  = class_total_ff
                          + TOT_W'(acc_hit && old_zero && (cnt_new != '0));
   assign weight_total_in = acc_hit ? tot_new : weight_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_total_ff  <= '0;
         weight_total_ff <= '0;
      end else if (cmd.commit) begin
         class_total_ff  <= class_total_in;
         weight_total_ff <= weight_total_in;
      end
   end

   // ---------------- result register ----------------
   logic [CRW-1:0]   xy_in;
   logic [CRW-1:0]   yx_in;
   logic [CRW-1:0]   xx_in;
   logic [CRW-1:0]   yy_in;
   logic [wpch_pkg::STATUS_W-1:0] status_in;
   logic             report_in;
   logic [WW-1:0]    sx_in;
   logic [WW-1:0]    sy_in;
   logic [BW-1:0]    sbeta_in;
   logic [CNT_W-1:0] count_in;

   logic [CRW-1:0]   xy_ff;
   logic [CRW-1:0]   yx_ff;
   logic [CRW-1:0]   xx_ff;
   logic [CRW-1:0]   yy_ff;
   logic [wpch_pkg::STATUS_W-1:0] status_ff;
   logic             report_ff;
   logic [WW-1:0]    sx_ff;
   logic [WW-1:0]    sy_ff;
   logic [BW-1:0]    sbeta_ff;
   logic [CNT_W-1:0] count_ff;

   assign f_xy_pad = {CRW'(0), idx_ff[4*CW-1 -: CW]};
   assign f_yx_pad = {CRW'(0), idx_ff[3*CW-1 -: CW]};
   assign f_xx_pad = {CRW'(0), idx_ff[2*CW-1 -: CW]};
   assign f_yy_pad = {CRW'(0), idx_ff[CW-1:0]};

   always_comb begin
      xy_in     = '0;
      yx_in     = '0;
      xx_in     = '0;
      yy_in     = '0;
      status_in = wpch_pkg::ST_SKIP;
      report_in = 1'b0;
      sx_in     = '0;
      sy_in     = '0;
      sbeta_in  = '0;
      count_in  = '0;
      if (!skip_ff || is_read) begin
         xy_in = f_xy_pad[CRW-1:0];
         yx_in = f_yx_pad[CRW-1:0];
         xx_in = f_xx_pad[CRW-1:0];
         yy_in = f_yy_pad[CRW-1:0];
      end
      if (is_read) begin
         status_in = wpch_pkg::ST_READ;
         count_in  = count_rd_ff;
         if (!old_zero) begin
            sx_in    = first_x;
            sy_in    = first_y;
            sbeta_in = sb;
         end
      end else if (acc_hit) begin
         count_in = cnt_new;
         if (old_zero) begin
            status_in = wpch_pkg::ST_NEW;
            report_in = (beta_ff > wpch_pkg::REPORT_BETA_MIN);
            sx_in     = a_ff;
            sy_in     = b_ff;
         end else begin
            status_in = wpch_pkg::ST_EXISTING;
            report_in = rep_old;
            sx_in     = first_x;
            sy_in     = first_y;
            sbeta_in  = sb;
         end
      end
   end

   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         xy_ff     <= xy_in;
         yx_ff     <= yx_in;
         xx_ff     <= xx_in;
         yy_ff     <= yy_in;
         status_ff <= status_in;
         report_ff <= report_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         sbeta_ff  <= sbeta_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_corr_xy     = xy_ff;
   assign rsp_corr_yx     = yx_ff;
   assign rsp_corr_xx     = xx_ff;
   assign rsp_corr_yy     = yy_ff;
   assign rsp_status      = status_ff;
   assign rsp_report      = report_ff;
   assign rsp_stored_x    = sx_ff;
   assign rsp_stored_y    = sy_ff;
   assign rsp_stored_beta = sbeta_ff;
   assign rsp_count       = count_ff;

   // Totals change only at a commit, so they match the held result
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_classes_total = wpch_pkg::TOTAL_W'(class_total_ff);
   assign rsp_pairs_total   = weight_total_ff;

   assign stat.clear_last  = &clr_addr_ff;
   assign stat.out_blocked = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

### rtl/word_pair_correlation_histogram.sv
// Top level of the word pair correlation histogram: controller, datapath and checks.
//
//   Channel | Direction | Handshake            | Carries
//   req_    | in        | req_valid/req_stall  | cmd, word pair, weight, beta, read index
//   rsp_    | out       | rsp_valid/rsp_stall  | correlations, status, stored class, totals
//   csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// The transfer loads the capture registers; the result becomes valid after these steps:
// correlate and form the entry index, read the histogram memories, then update and
// load the result register. The next item is taken the cycle after the update, not
// before; one item in flight at a time keeps each read then write of the histogram
// free of overlap.
// After reset a clearing pass over all 2^(4*(MAX_WORD_LEN-1)) entries (4096 by default)
// zeroes the counts while req_stall stays high; register writes are taken meanwhile.
// A stalled result holds in the output register and the update waits until it leaves.
`default_nettype none

module word_pair_correlation_histogram #(
   parameter int MAX_WORD_LEN  = wpch_pkg::DEF_MAX_WORD_LEN,
   parameter int MAX_CHAR_BITS = wpch_pkg::DEF_MAX_CHAR_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [wpch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wpch_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cmd,
   input  wire logic [wpch_pkg::WORD_W-1:0]        req_word_x,
   input  wire logic [wpch_pkg::WORD_W-1:0]        req_word_y,
   input  wire logic [wpch_pkg::WEIGHT_W-1:0]      req_weight,
   input  wire logic [wpch_pkg::BETA_W-1:0]        req_distinct_chars,
   input  wire logic [wpch_pkg::RDIDX_W-1:0]       req_read_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_xy,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_yx,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_xx,
   output logic      [wpch_pkg::CORR_W-1:0]        rsp_corr_yy,
   output logic      [wpch_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                    rsp_report,
   output logic      [wpch_pkg::WORD_W-1:0]        rsp_stored_x,
   output logic      [wpch_pkg::WORD_W-1:0]        rsp_stored_y,
   output logic      [wpch_pkg::BETA_W-1:0]        rsp_stored_beta,
   output logic      [wpch_pkg::COUNT_W-1:0]       rsp_count,
   output logic      [wpch_pkg::TOTAL_W-1:0]       rsp_classes_total,
   output logic      [wpch_pkg::COUNT_W-1:0]       rsp_pairs_total
);

   wpch_pkg::ctrl_cmd_type  cmd_w;
   wpch_pkg::dp_status_type stat_w;

   // Sequencer: clearing pass, then one item at a time through four steps
   wpch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat_w),
      .cmd       (cmd_w)
   );

   // Configuration, correlation units, histogram memories and result register
   wpch_datapath #(
      .MAX_WORD_LEN  (MAX_WORD_LEN),
      .MAX_CHAR_BITS (MAX_CHAR_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd_w),
      .stat               (stat_w),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_cmd            (req_cmd),
      .req_word_x         (req_word_x),
      .req_word_y         (req_word_y),
      .req_weight         (req_weight),
      .req_distinct_chars (req_distinct_chars),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_corr_xy        (rsp_corr_xy),
      .rsp_corr_yx        (rsp_corr_yx),
      .rsp_corr_xx        (rsp_corr_xx),
      .rsp_corr_yy        (rsp_corr_yy),
      .rsp_status         (rsp_status),
      .rsp_report         (rsp_report),
      .rsp_stored_x       (rsp_stored_x),
      .rsp_stored_y       (rsp_stored_y),
      .rsp_stored_beta    (rsp_stored_beta),
      .rsp_count          (rsp_count),
      .rsp_classes_total  (rsp_classes_total),
      .rsp_pairs_total    (rsp_pairs_total)
   );

   // One item in flight: after a transfer the input side stays stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input transfer taken while an item is in flight");

   // The controller issues at most one datapath step per cycle
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd_w))
      else $error("more than one datapath command at once");

   // A committed update always shows up as a valid result
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd_w.commit |=> rsp_valid)
      else $error("committed update did not produce a result");

   // No update overwrites a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd_w.commit)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the word pair correlation histogram.
`default_nettype none

module tb;
   import wpch_pkg::*;

   localparam int MAX_LEN       = DEF_MAX_WORD_LEN;
   localparam int MAX_BITS      = DEF_MAX_CHAR_BITS;
   localparam int IDLE_PCT      = 21;
   localparam int SETTLE_CYCLES = 8;      // leave margin past the block's update steps
   localparam int TAIL_CYCLES   = 24;
   localparam int CALM_FIRST    = 600;    // no idling on either side in this window
   localparam int CALM_LAST     = 900;
   localparam int LIMIT_CYCLES  = 250000; // clearing pass plus ~1600 items, many times over

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_e;

   typedef struct {
      op_kind_e                 kind;
      logic                     cmd;
      logic [WORD_W-1:0]        word_x;
      logic [WORD_W-1:0]        word_y;
      logic [WEIGHT_W-1:0]      weight;
      logic [BETA_W-1:0]        beta;
      logic [RDIDX_W-1:0]       read_index;
      logic [CSR_IDX_W-1:0]     reg_index;
      logic [CSR_DATA_W-1:0]    reg_data;
   } pending_op_t;

   // Ordered correlation values; as a packed word this is the histogram entry index.
   typedef struct packed {
      logic [CORR_W-1:0] xy;
      logic [CORR_W-1:0] yx;
      logic [CORR_W-1:0] xx;
      logic [CORR_W-1:0] yy;
   } corr_quad_t;

   typedef struct packed {
      logic [CORR_W-1:0]   corr_xy;
      logic [CORR_W-1:0]   corr_yx;
      logic [CORR_W-1:0]   corr_xx;
      logic [CORR_W-1:0]   corr_yy;
      logic [STATUS_W-1:0] status;
      logic                report;
      logic [WORD_W-1:0]   stored_x;
      logic [WORD_W-1:0]   stored_y;
      logic [BETA_W-1:0]   stored_beta;
      logic [COUNT_W-1:0]  count;
      logic [TOTAL_W-1:0]  classes_total;
      logic [COUNT_W-1:0]  pairs_total;
   } class_result_t;

   // Clock, reset and block ports; every input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = CMD_ACC;
   logic [WORD_W-1:0]     req_word_x = '0;
   logic [WORD_W-1:0]     req_word_y = '0;
   logic [WEIGHT_W-1:0]   req_weight = '0;
   logic [BETA_W-1:0]     req_distinct_chars = '0;
   logic [RDIDX_W-1:0]    req_read_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CORR_W-1:0]     rsp_corr_xy;
   logic [CORR_W-1:0]     rsp_corr_yx;
   logic [CORR_W-1:0]     rsp_corr_xx;
   logic [CORR_W-1:0]     rsp_corr_yy;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_report;
   logic [WORD_W-1:0]     rsp_stored_x;
   logic [WORD_W-1:0]     rsp_stored_y;
   logic [BETA_W-1:0]     rsp_stored_beta;
   logic [COUNT_W-1:0]    rsp_count;
   logic [TOTAL_W-1:0]    rsp_classes_total;
   logic [COUNT_W-1:0]    rsp_pairs_total;

   // Predictor state: histogram, first-hit records, totals and register copies
   logic [COUNT_W-1:0] hist_count [1 << (4 * CORR_W)];
   logic [FIRST_W-1:0] hist_first [1 << (4 * CORR_W)];
   logic [TOTAL_W-1:0] classes_seen = '0;
   logic [COUNT_W-1:0] weight_sum = '0;
   logic [WL_W-1:0]    len_setting = WL_RESET;
   logic [CB_W-1:0]    bits_setting = CB_RESET;

   pending_op_t   pending_ops [$];
   class_result_t awaited_results [$];
   pending_op_t   active_op;
   int            sent_items = 0;
   int            seen_results = 0;
   int            quiet_cycles = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   word_pair_correlation_histogram u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_word_x         (req_word_x),
      .req_word_y         (req_word_y),
      .req_weight         (req_weight),
      .req_distinct_chars (req_distinct_chars),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_corr_xy        (rsp_corr_xy),
      .rsp_corr_yx        (rsp_corr_yx),
      .rsp_corr_xx        (rsp_corr_xx),
      .rsp_corr_yy        (rsp_corr_yy),
      .rsp_status         (rsp_status),
      .rsp_report         (rsp_report),
      .rsp_stored_x       (rsp_stored_x),
      .rsp_stored_y       (rsp_stored_y),
      .rsp_stored_beta    (rsp_stored_beta),
      .rsp_count          (rsp_count),
      .rsp_classes_total  (rsp_classes_total),
      .rsp_pairs_total    (rsp_pairs_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp the raw register values into the supported range
   function automatic int eff_len(logic [WL_W-1:0] v);
      if (v < WL_MIN) return int'(WL_MIN);
      if (v > MAX_LEN) return MAX_LEN;
      return int'(v);
   endfunction

   function automatic int eff_bits(logic [CB_W-1:0] v);
      if (v < CB_MIN) return int'(CB_MIN);
      if (v > MAX_BITS) return MAX_BITS;
      return int'(v);
   endfunction

   function automatic logic [WORD_W-1:0] word_mask(int t, int nb);
      return WORD_W'((1 << (t * nb)) - 1);
   endfunction

   // One bit per shift 1..t-1, shift 1 most significant: set where the
   // characters of a agree with b moved right by that shift.
   function automatic logic [CORR_W-1:0] overlap_bits(logic [WORD_W-1:0] a,
                                                      logic [WORD_W-1:0] b, int t, int nb);
      logic [CORR_W-1:0] v;
      logic [WORD_W-1:0] m;
      v = '0;
      for (int k = 1; k < t; k++) begin
         m = WORD_W'((1 << ((t - k) * nb)) - 1);
         v = {v[CORR_W-2:0], ((a ^ (b >> (k * nb))) & m) == '0};
      end
      return v;
   endfunction

   // Cross and auto pairs, each ordered larger first
   function automatic corr_quad_t pair_correlations(logic [WORD_W-1:0] a,
                                                    logic [WORD_W-1:0] b, int t, int nb);
      corr_quad_t q;
      logic [CORR_W-1:0] swap;
      q.xy = overlap_bits(a, b, t, nb);
      q.yx = overlap_bits(b, a, t, nb);
      q.xx = overlap_bits(a, a, t, nb);
      q.yy = overlap_bits(b, b, t, nb);
      if (q.xy < q.yx) begin
         swap = q.xy;
         q.xy = q.yx;
         q.yx = swap;
      end
      if (q.xx < q.yy) begin
         swap = q.xx;
         q.xx = q.yy;
         q.yy = swap;
      end
      return q;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add48(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = a + b;
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

   // Work out the result of one accepted transfer and update the histogram copy
   task automatic predict_histogram_result(input pending_op_t it);
      class_result_t      r;
      corr_quad_t         q;
      logic [WORD_W-1:0]  a, b;
      logic [COUNT_W-1:0] old_cnt;
      logic [BETA_W-1:0]  sb;
      logic               rep;
      int                 t, nb;
      t = eff_len(len_setting);
      nb = eff_bits(bits_setting);
      r = '0;
      if (it.cmd == CMD_READ) begin
         q = corr_quad_t'(it.read_index);
         r.corr_xy = q.xy;
         r.corr_yx = q.yx;
         r.corr_xx = q.xx;
         r.corr_yy = q.yy;
         r.status = ST_READ;
         if (hist_count[q] != '0)
            {r.stored_x, r.stored_y, r.stored_beta} = hist_first[q];
         r.count = hist_count[q];
      end else begin
         a = it.word_x & word_mask(t, nb);
         b = it.word_y & word_mask(t, nb);
         if (a == b) begin
            r.status = ST_SKIP;
         end else begin
            q = pair_correlations(a, b, t, nb);
            old_cnt = hist_count[q];
            if (old_cnt == '0) begin
               // first hit, or the entry is still empty after zero weights: record anew
               hist_first[q] = {a, b, it.beta};
               r.status = ST_NEW;
               r.report = it.beta > REPORT_BETA_MIN;
               r.stored_x = a;
               r.stored_y = b;
            end else begin
               sb = hist_first[q][BETA_W-1:0];
               rep = it.beta > REPORT_BETA_MIN && it.beta > sb && sb > STORED_BETA_MIN;
               r.status = ST_EXISTING;
               r.report = rep;
               {r.stored_x, r.stored_y, r.stored_beta} = hist_first[q];
               if (rep)
                  hist_first[q][BETA_W-1:0] = it.beta;
            end
            hist_count[q] = sat_add48(old_cnt, it.weight);
            if (old_cnt == '0 && hist_count[q] != '0)
               classes_seen = classes_seen + 1'b1;
            weight_sum = sat_add48(weight_sum, it.weight);
            r.corr_xy = q.xy;
            r.corr_yx = q.yx;
            r.corr_xx = q.xx;
            r.corr_yy = q.yy;
            r.count = hist_count[q];
         end
      end
      r.classes_total = classes_seen;
      r.pairs_total = weight_sum;
      awaited_results.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Stimulus builders: append to the queue the driver works from
   task automatic push_setting(input logic [CSR_DATA_W-1:0] len_data,
                               input logic [CSR_DATA_W-1:0] bits_data);
      pending_op_t op;
      op = '{kind: OP_CSR, cmd: CMD_ACC, default: '0};
      op.reg_index = REG_WORD_LEN;
      op.reg_data = len_data;
      pending_ops.push_back(op);
      op.reg_index = REG_CHAR_BITS;
      op.reg_data = bits_data;
      pending_ops.push_back(op);
   endtask

   task automatic push_pair(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                            input logic [WEIGHT_W-1:0] w, input logic [BETA_W-1:0] beta);
      pending_op_t op;
      op = '{kind: OP_ITEM, cmd: CMD_ACC, default: '0};
      op.word_x = x;
      op.word_y = y;
      op.weight = w;
      op.beta = beta;
      op.read_index = WORD_W'($urandom());  // ignored on accumulate, keep it noisy
      pending_ops.push_back(op);
   endtask

   task automatic push_read(input logic [RDIDX_W-1:0] idx);
      pending_op_t op;
      op = '{kind: OP_ITEM, cmd: CMD_READ, default: '0};
      op.read_index = idx;
      op.word_x = WORD_W'($urandom());
      op.word_y = WORD_W'($urandom());
      op.weight = WEIGHT_W'($urandom());
      op.beta = BETA_W'($urandom());
      pending_ops.push_back(op);
   endtask

   task automatic push_drain();
      pending_op_t op;
      op = '{kind: OP_DRAIN, cmd: CMD_ACC, default: '0};
      pending_ops.push_back(op);
   endtask

   // Mostly words over a two-letter alphabet so that correlations get rich;
   // some fully random, some with junk above the used width.
   function automatic logic [WORD_W-1:0] shaped_word(int t, int nb);
      logic [WORD_W-1:0] w;
      logic [3:0]        la, lb;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 30)
         return WORD_W'($urandom());
      la = 4'($urandom());
      lb = 4'($urandom());
      w = '0;
      for (int k = 0; k < t; k++)
         w = (w << nb) | WORD_W'((($urandom_range(1) != 0) ? la : lb) & ((1 << nb) - 1));
      if (pick < 45)
         w = w | WORD_W'($urandom() << (t * nb));
      return w;
   endfunction

   task automatic push_random_items(input int n, input int t, input int nb);
      logic [WORD_W-1:0]   x, y;
      logic [WEIGHT_W-1:0] w;
      logic [BETA_W-1:0]   beta;
      int                  sel;
      for (int i = 0; i < n; i++) begin
         x = shaped_word(t, nb);
         sel = $urandom_range(99);
         if (sel < 12) begin
            // read back an entry: half of them one that real pairs land on
            if ($urandom_range(1) != 0)
               push_read(RDIDX_W'($urandom()));
            else
               push_read(pair_correlations(x & word_mask(t, nb),
                                           shaped_word(t, nb) & word_mask(t, nb), t, nb));
         end else begin
            if (sel < 22)
               y = x ^ WORD_W'($urandom() << (t * nb));       // equal once masked
            else if (sel < 35)
               y = WORD_W'((x << nb) | $urandom_range(0, (1 << nb) - 1));
            else
               y = shaped_word(t, nb);
            case ($urandom_range(9))
               0:       w = '0;
               1:       w = '1;
               2, 3, 4: w = WEIGHT_W'($urandom_range(0, 15));
               default: w = WEIGHT_W'($urandom());
            endcase
            if ($urandom_range(99) < 80)
               beta = BETA_W'($urandom_range(2, 8));
            else
               beta = BETA_W'($urandom_range(0, 15));
            push_pair(x, y, w, beta);
         end
      end
   endtask

   // Driver: present one pending operation at a time on its channel
   always @(posedge clock) begin
      logic        req_took, csr_took, settled;
      logic        calm;
      pending_op_t op;
      req_took = req_valid && !req_stall;
      csr_took = csr_valid && csr_ready;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (req_took) begin
            predict_histogram_result(active_op);
            sent_items++;
         end
         if (csr_took) begin
            if (csr_index == REG_WORD_LEN)
               len_setting = csr_data;
            else
               bits_setting = csr_data[CB_W-1:0];
         end
         // count cycles with nothing in flight; config waits on this
         quiet_cycles <= (awaited_results.size() == 0 && !req_took) ? quiet_cycles + 1 : 0;
         settled = awaited_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
         calm = sent_items >= CALM_FIRST && sent_items < CALM_LAST;
         if ((req_valid && !req_took) || (csr_valid && !csr_took)) begin
            // hold the stalled transfer unchanged
         end else if (pending_ops.size() == 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else begin
            op = pending_ops[0];
            case (op.kind)
               OP_ITEM: begin
                  csr_valid <= 1'b0;
                  if (!calm && $urandom_range(99) < IDLE_PCT) begin
                     req_valid <= 1'b0;
                  end else begin
                     req_valid <= 1'b1;
                     req_cmd <= op.cmd;
                     req_word_x <= op.word_x;
                     req_word_y <= op.word_y;
                     req_weight <= op.weight;
                     req_distinct_chars <= op.beta;
                     req_read_index <= op.read_index;
                     active_op = op;
                     void'(pending_ops.pop_front());
                  end
               end
               OP_CSR: begin
                  // write registers only with the block drained
                  req_valid <= 1'b0;
                  if (settled) begin
                     csr_valid <= 1'b1;
                     csr_index <= op.reg_index;
                     csr_data <= op.reg_data;
                     void'(pending_ops.pop_front());
                  end else begin
                     csr_valid <= 1'b0;
                  end
               end
               default: begin
                  // pause until every awaited result is back
                  req_valid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (settled)
                     void'(pending_ops.pop_front());
               end
            endcase
         end
      end
   end

   // Monitor: take result transfers, compare with the oldest awaited result, stall at random
   always @(posedge clock) begin
      class_result_t got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_corr_xy, rsp_corr_yx, rsp_corr_xx, rsp_corr_yy, rsp_status, rsp_report,
                   rsp_stored_x, rsp_stored_y, rsp_stored_beta, rsp_count,
                   rsp_classes_total, rsp_pairs_total};
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited");
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("corr_xy", want.corr_xy, got.corr_xy);
               check_field("corr_yx", want.corr_yx, got.corr_yx);
               check_field("corr_xx", want.corr_xx, got.corr_xx);
               check_field("corr_yy", want.corr_yy, got.corr_yy);
               check_field("status", want.status, got.status);
               check_field("report", want.report, got.report);
               check_field("stored_x", want.stored_x, got.stored_x);
               check_field("stored_y", want.stored_y, got.stored_y);
               check_field("stored_beta", want.stored_beta, got.stored_beta);
               check_field("count", want.count, got.count);
               check_field("classes_total", want.classes_total, got.classes_total);
               check_field("pairs_total", want.pairs_total, got.pairs_total);
            end
            seen_results++;
         end
         if (seen_results >= CALM_FIRST && seen_results < CALM_LAST)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= $urandom_range(99) < IDLE_PCT;
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      corr_quad_t hot_slot, spare_slot;
      for (int i = 0; i < (1 << (4 * CORR_W)); i++) begin
         hist_count[i] = '0;
         hist_first[i] = '0;
      end

      // Directed part at full width: 4 characters of 3 bits
      push_setting(3'd4, 3'd3);
      push_read('0);                              // empty entry
      push_read('1);
      push_pair(12'h000, 12'h000, 20'd1, 4'd2);   // equal words
      push_pair(12'hFFF, 12'hFFF, 20'd9, 4'd8);
      push_pair(12'h000, 12'hFFF, '1, 4'd8);      // new class, report
      push_pair(12'h000, 12'hFFF, 20'd7, 4'd15);  // existing, stored beta below: report
      push_pair(12'h000, 12'hFFF, 20'd3, 4'd9);   // existing, stored beta above: none
      push_pair(12'h123, 12'h456, 20'd0, 4'd3);   // zero weight leaves the entry empty
      push_pair(12'h123, 12'h456, 20'd5, 4'd3);   // so this is new again
      push_pair(12'h123, 12'h456, 20'd1, 4'd4);   // stored beta 3 raised to 4
      push_pair(12'h123, 12'h456, 20'd1, 4'd0);
      hot_slot = pair_correlations(12'h123, 12'h456, 4, 3);
      spare_slot = pair_correlations(12'h000, 12'hFFF, 4, 3);
      push_read(hot_slot);
      push_read(spare_slot);
      push_pair(12'h249, 12'h492, 20'd2, 4'd5);   // periodic words, rich autocorrelation
      push_pair(12'h249, 12'h249, 20'd2, 4'd5);
      push_pair(12'h0F0, 12'h00F, '1, 4'd15);
      push_pair(12'h007, 12'h008, 20'd1, 4'd2);
      push_random_items(300, 4, 3);

      // Narrowest: 2 characters of 1 bit, junk above bit 1 must be dropped
      push_setting(3'd2, 3'd1);
      push_pair(12'hFFC, 12'h000, 20'd4, 4'd6);   // equal once masked
      push_pair(12'hFFD, 12'hAAE, 20'd4, 4'd6);
      push_pair(12'h001, 12'h003, 20'd4, 4'd6);
      push_read('0);
      push_random_items(100, 2, 1);

      // Below range on both registers: clamps to the narrowest
      push_setting(3'd0, 3'd4);
      push_random_items(100, 2, 1);

      // Above range on both: clamps to the widest; pause once mid-phase
      push_setting(3'd7, 3'd7);
      push_random_items(250, 4, 3);
      push_drain();
      push_random_items(250, 4, 3);

      push_setting(3'd3, 3'd2);
      push_random_items(250, 3, 2);

      push_setting(3'd1, 3'd5);
      push_random_items(100, 2, 1);

      push_setting(3'd4, 3'd2);
      push_random_items(250, 4, 2);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the stimulus to drain and every result to come back
      while (pending_ops.size() != 0 || req_valid || csr_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d awaited results never came", awaited_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
